@@ rtl/tpvi_pkg.sv @@
package tpvi_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int GAIN_W    = 24;
    localparam int AXIS_W    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int VEL_W     = 20;
    localparam int ERR_W     = 33;
    localparam int PROD_W    = 57;
    localparam int ACC_W     = 59;
    localparam int STEP_W    = 28;
    localparam int SUM_W     = 29;
    localparam int RATE_SHIFT = 18;
    localparam int STEP_SHIFT = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_ROLL  = 3'd0,
        REG_KP_PITCH = 3'd1,
        REG_KD_ROLL  = 3'd2,
        REG_KD_PITCH = 3'd3,
        REG_REF_X    = 3'd4,
        REG_REF_Y    = 3'd5,
        REG_REF_Z    = 3'd6
    } cfg_reg_t;

    // One strobe per working sequencer step (none for idle or push), shared by both lanes.
    typedef struct packed {
        logic mul0;
        logic mul1;
        logic err;
        logic mul_kp;
        logic mul_kd;
        logic sum;
        logic upd;
    } lane_ctrl_t;

endpackage

@@ rtl/tpvi_lane.sv @@
module tpvi_lane #(
    parameter int LIMIT = 327680
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  tpvi_pkg::lane_ctrl_t                      ctrl,
    input  logic signed [tpvi_pkg::AXIS_W-1:0]        ref_a,
    input  logic signed [tpvi_pkg::SAMPLE_W-1:0]      vert_a,
    input  logic signed [tpvi_pkg::AXIS_W-1:0]        ref_b,
    input  logic signed [tpvi_pkg::SAMPLE_W-1:0]      vert_b,
    input  logic signed [tpvi_pkg::SAMPLE_W-1:0]      rate,
    input  logic signed [tpvi_pkg::GAIN_W-1:0]        kp,
    input  logic signed [tpvi_pkg::GAIN_W-1:0]        kd,
    output logic signed [tpvi_pkg::VEL_W-1:0]         velocity
);
    import tpvi_pkg::*;

    localparam logic signed [SUM_W-1:0] LIM = SUM_W'(LIMIT);

    logic signed [ERR_W-1:0]  mul_a;
    logic signed [GAIN_W-1:0] mul_b;
    logic signed [PROD_W-1:0] product;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [ERR_W-1:0]  e_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W:0]    neg_acc;
    logic signed [STEP_W-1:0] step;
    logic signed [SUM_W-1:0]  vel_sum;
    logic signed [SUM_W-1:0]  vel_clamped;
    logic signed [VEL_W-1:0]  vel_reg;
    logic signed [VEL_W-1:0]  vel_next;

    // Operand select for the one multiplier of this lane.
    always_comb
    begin
        if (ctrl.mul1)
        begin
            mul_a = ERR_W'(ref_b);
            mul_b = GAIN_W'(vert_b);
        end
        else if (ctrl.mul_kp)
        begin
            mul_a = e_reg;
            mul_b = kp;
        end
        else if (ctrl.mul_kd)
        begin
            mul_a = ERR_W'(rate);
            mul_b = kd;
        end
        else
        begin
            mul_a = ERR_W'(ref_a);
            mul_b = GAIN_W'(vert_a);
        end
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Load kp*error, then add the damping term: kd*rate fits 41 bits, scale it up by 2^18.
    always_comb
    begin
        if (ctrl.sum)
            acc_next = acc_reg + $signed({p_reg[ACC_W-RATE_SHIFT-1:0], {RATE_SHIFT{1'b0}}});
        else
            acc_next = ACC_W'(p_reg);
    end

    // Negate, drop 32 fraction bits toward minus infinity, add and clamp.
    always_comb
    begin
        neg_acc = -((ACC_W+1)'(acc_reg));
        step    = neg_acc[ACC_W:STEP_SHIFT];
        vel_sum = SUM_W'(vel_reg) + SUM_W'(step);
        if (vel_sum <= -LIM)
            vel_clamped = -LIM;
        else if (vel_sum >= LIM)
            vel_clamped = LIM;
        else
            vel_clamped = vel_sum;
        vel_next = vel_clamped[VEL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul0 || ctrl.mul1 || ctrl.mul_kp || ctrl.mul_kd)
            p_reg <= product;
        if (ctrl.mul1)
            e_reg <= p_reg[ERR_W-1:0];
        else if (ctrl.err)
            e_reg <= e_reg - p_reg[ERR_W-1:0];
        if (ctrl.mul_kd || ctrl.sum)
            acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vel_reg <= '0;
        else if (ctrl.upd)
            vel_reg <= vel_next;
    end

    assign velocity = vel_reg;

endmodule

@@ rtl/tpvi_merge.sv @@
module tpvi_merge (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic signed [tpvi_pkg::VEL_W-1:0]    roll_in,
    input  logic signed [tpvi_pkg::VEL_W-1:0]    pitch_in,
    output logic                                 free,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tpvi_pkg::VEL_W-1:0]    omega_roll,
    output logic signed [tpvi_pkg::VEL_W-1:0]    omega_pitch
);
    import tpvi_pkg::*;

    logic                    valid_reg;
    logic signed [VEL_W-1:0] roll_reg;
    logic signed [VEL_W-1:0] pitch_reg;
    logic                    load;

    // Slot is free when empty or drained this cycle.
    assign free = !valid_reg || out_ready;
    assign load = push && free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            roll_reg  <= roll_in;
            pitch_reg <= pitch_in;
        end
    end

    assign out_valid   = valid_reg;
    assign omega_roll  = roll_reg;
    assign omega_pitch = pitch_reg;

endmodule

@@ rtl/tilt_pd_velocity_integrator.sv @@
// Tilt PD controller with integrated, clamped roll and pitch velocity commands.
// Input channel (in_valid/in_ready): one IMU sample per transaction, the
// world vertical axis in the IMU frame (Q1.14) and the roll and pitch rates.
// Output channel (out_valid/out_ready): one transaction per sample carrying
// the clamped roll and pitch velocities (value/65536 rad/s).
// Configuration: write cfg_data into register cfg_index while cfg_we is high;
// indexes beyond the register list are dropped. Write only while idle.
// Two lanes, roll and pitch, run in lockstep; each owns one 33x24 multiplier
// reused for four products (two cross-product terms, kp*error, kd*rate).
// After the input transaction the sequencer steps through MUL0, MUL1, ERR,
// MULKP, MULKD, SUM, UPD and PUSH; out_valid rises once the output slot is free.
// No new sample is taken until the sequencer is back in idle.
// A new sample is taken while the previous result still waits in the output
// register; if the receiver stalls longer, the sequencer holds the finished
// result in its push step and takes no input until the slot drains.
// Reset clears both velocities to zero and loads the default gains and
// reference axis (0, 0, 1).
module tilt_pd_velocity_integrator #(
    parameter int ROLL_LIMIT  = 327680,
    parameter int PITCH_LIMIT = 327680
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [tpvi_pkg::SAMPLE_W-1:0]      vertical_x,
    input  logic signed [tpvi_pkg::SAMPLE_W-1:0]      vertical_y,
    input  logic signed [tpvi_pkg::SAMPLE_W-1:0]      vertical_z,
    input  logic signed [tpvi_pkg::SAMPLE_W-1:0]      rate_roll,
    input  logic signed [tpvi_pkg::SAMPLE_W-1:0]      rate_pitch,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [tpvi_pkg::VEL_W-1:0]         omega_roll,
    output logic signed [tpvi_pkg::VEL_W-1:0]         omega_pitch,
    input  logic                                      cfg_we,
    input  logic [tpvi_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [tpvi_pkg::GAIN_W-1:0]               cfg_data
);
    import tpvi_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MUL0  = 9'b000000010,
        ST_MUL1  = 9'b000000100,
        ST_ERR   = 9'b000001000,
        ST_MULKP = 9'b000010000,
        ST_MULKD = 9'b000100000,
        ST_SUM   = 9'b001000000,
        ST_UPD   = 9'b010000000,
        ST_PUSH  = 9'b100000000
    } seq_state_t;

    seq_state_t state_reg, state_next;

    logic signed [GAIN_W-1:0] kp_roll_reg, kp_pitch_reg, kd_roll_reg, kd_pitch_reg;
    logic signed [AXIS_W-1:0] ref_x_reg, ref_y_reg, ref_z_reg;

    logic signed [SAMPLE_W-1:0] vx_reg, vy_reg, vz_reg, wr_reg, wp_reg;

    lane_ctrl_t               ctrl;
    logic signed [VEL_W-1:0]  roll_vel, pitch_vel;
    logic                     out_free;
    logic                     in_fire;

    // Configuration registers: plain write port, unknown indexes ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_roll_reg  <= GAIN_W'(1049);
            kp_pitch_reg <= GAIN_W'(1049);
            kd_roll_reg  <= GAIN_W'(105);
            kd_pitch_reg <= GAIN_W'(105);
            ref_x_reg    <= '0;
            ref_y_reg    <= '0;
            ref_z_reg    <= AXIS_W'(16384);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KP_ROLL:  kp_roll_reg  <= cfg_data;
                REG_KP_PITCH: kp_pitch_reg <= cfg_data;
                REG_KD_ROLL:  kd_roll_reg  <= cfg_data;
                REG_KD_PITCH: kd_pitch_reg <= cfg_data;
                REG_REF_X:    ref_x_reg    <= cfg_data[AXIS_W-1:0];
                REG_REF_Y:    ref_y_reg    <= cfg_data[AXIS_W-1:0];
                REG_REF_Z:    ref_z_reg    <= cfg_data[AXIS_W-1:0];
                default:      ;
            endcase
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // Hold the sample for the whole sequence.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            vx_reg <= vertical_x;
            vy_reg <= vertical_y;
            vz_reg <= vertical_z;
            wr_reg <= rate_roll;
            wp_reg <= rate_pitch;
        end
    end

    // Sequencer: walk both lanes through their multiplier passes.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_MUL0;
            ST_MUL0:  state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_ERR;
            ST_ERR:   state_next = ST_MULKP;
            ST_MULKP: state_next = ST_MULKD;
            ST_MULKD: state_next = ST_SUM;
            ST_SUM:   state_next = ST_UPD;
            ST_UPD:   state_next = ST_PUSH;
            ST_PUSH:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        ctrl.mul0   = (state_reg == ST_MUL0);
        ctrl.mul1   = (state_reg == ST_MUL1);
        ctrl.err    = (state_reg == ST_ERR);
        ctrl.mul_kp = (state_reg == ST_MULKP);
        ctrl.mul_kd = (state_reg == ST_MULKD);
        ctrl.sum    = (state_reg == ST_SUM);
        ctrl.upd    = (state_reg == ST_UPD);
    end

    // Roll lane: error = ry*vz - rz*vy.
    tpvi_lane #(
        .LIMIT (ROLL_LIMIT)
    ) u_lane_roll (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .ref_a    (ref_y_reg),
        .vert_a   (vz_reg),
        .ref_b    (ref_z_reg),
        .vert_b   (vy_reg),
        .rate     (wr_reg),
        .kp       (kp_roll_reg),
        .kd       (kd_roll_reg),
        .velocity (roll_vel)
    );

    // Pitch lane: error = rz*vx - rx*vz.
    tpvi_lane #(
        .LIMIT (PITCH_LIMIT)
    ) u_lane_pitch (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .ref_a    (ref_z_reg),
        .vert_a   (vx_reg),
        .ref_b    (ref_x_reg),
        .vert_b   (vz_reg),
        .rate     (wp_reg),
        .kp       (kp_pitch_reg),
        .kd       (kd_pitch_reg),
        .velocity (pitch_vel)
    );

    // Merge both lanes into one output transaction.
    tpvi_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (state_reg == ST_PUSH),
        .roll_in     (roll_vel),
        .pitch_in    (pitch_vel),
        .free        (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .omega_roll  (omega_roll),
        .omega_pitch (omega_pitch)
    );

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_MUL0 && !in_ready)
        else $error("accepted sample did not start the sequence");

    a_push_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUSH && out_free |=> out_valid && state_reg == ST_IDLE)
        else $error("finished result not loaded into output slot");

    a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUSH && !out_free |=> state_reg == ST_PUSH)
        else $error("result dropped while receiver stalled");

    a_roll_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (SUM_W'(omega_roll) <= SUM_W'(ROLL_LIMIT))
                   && (SUM_W'(omega_roll) >= -SUM_W'(ROLL_LIMIT)))
        else $error("roll command outside clamp limit");

    a_pitch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (SUM_W'(omega_pitch) <= SUM_W'(PITCH_LIMIT))
                   && (SUM_W'(omega_pitch) >= -SUM_W'(PITCH_LIMIT)))
        else $error("pitch command outside clamp limit");
`endif

endmodule
